// ===== design/srtq_pkg.sv =====
// Shared types and constants for the sorted priority task queue.
`default_nettype none

package srtq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // S_SCAN walks the list, S_DROP closes a gap, S_OPEN makes room for an insert
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DROP = 2'd2,
    S_OPEN = 2'd3
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/srtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sorted_priority_task_queue.sv =====
// Top level of the sorted priority task queue: sequencer around one entry RAM.
//
// Usage: a command word (cmd, task_id, task_priority) is taken at a rising
// edge where start is high and busy is low. Insert places the entry behind
// every stored entry of greater or equal priority; pop removes the head;
// delete removes the entry with the given id. Each command gives exactly
// one result word (status, removed_id, removed_priority, occupancy), shown
// for one cycle with done high. The receiver cannot stall, so results are
// simply registered outputs valid during the done cycle.
// Sequencing: all entries sit in one RAM with one read and one write port,
// and every list walk or shift moves one entry per cycle through it.
// Errors found up front (empty queue, unused command) need no walk. Insert
// scans the whole list; unless it finds a duplicate id or a full queue, it
// then moves the entries from the tail down to its place one slot back and
// writes the new entry. Pop and delete scan up to the hit, then move every
// later entry one slot toward the head. busy is high from acceptance until
// the done cycle; a new command may be started in the done cycle.
// Reset: clears the entry count and the sequencer only; stored entries are
// not cleared, since no slot at or above the count is ever read.
`default_nettype none

module sorted_priority_task_queue #(
  parameter int QUEUE_DEPTH = srtq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [srtq_pkg::CMD_W-1:0]    cmd,
  input  wire logic [srtq_pkg::ID_W-1:0]     task_id,
  input  wire logic [srtq_pkg::PRIO_W-1:0]   task_priority,
  output logic                               done,
  output logic      [srtq_pkg::STATUS_W-1:0] status,
  output logic      [srtq_pkg::ID_W-1:0]     removed_id,
  output logic      [srtq_pkg::PRIO_W-1:0]   removed_priority,
  output logic      [srtq_pkg::OCC_W-1:0]    occupancy
);

  import srtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  cmd_t              cmd_r, cmd_r_next;
  logic [ID_W-1:0]   id_r, id_r_next;
  logic [PRIO_W-1:0] prio_r, prio_r_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic              pend_v, pend_v_next;
  logic [CW-1:0]     pend_idx, pend_idx_next;
  logic [CW-1:0]     pos, pos_next;
  logic              pos_set, pos_set_next;
  logic              dup, dup_next;
  logic              done_next;
  logic [STATUS_W-1:0] status_next;
  logic [ID_W-1:0]   removed_id_next;
  logic [PRIO_W-1:0] removed_priority_next;
  logic [CW+4:0]     occ_wide;

  // RAM port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  logic [CW-1:0]     prev_ptr;
  logic [CW-1:0]     drop_addr;

  srtq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign prev_ptr  = ptr - CW'(1);
  assign drop_addr = pend_idx - CW'(1);
  assign occ_wide  = (CW + 5)'(count_next);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      pend_v  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pend_v  <= pend_v_next;
      done    <= done_next;
    end
  end

  // command and result word registers
  always_ff @(posedge clk) begin
    cmd_r            <= cmd_r_next;
    id_r             <= id_r_next;
    prio_r           <= prio_r_next;
    ptr              <= ptr_next;
    pend_idx         <= pend_idx_next;
    pos              <= pos_next;
    pos_set          <= pos_set_next;
    dup              <= dup_next;
    status           <= status_next;
    removed_id       <= removed_id_next;
    removed_priority <= removed_priority_next;
    occupancy        <= occ_wide[OCC_W-1:0];
  end

  // sequencer: next state, RAM access and result word
  always_comb begin
    state_next            = state;
    count_next            = count;
    cmd_r_next            = cmd_r;
    id_r_next             = id_r;
    prio_r_next           = prio_r;
    ptr_next              = ptr;
    pend_v_next           = 1'b0;
    pend_idx_next         = pend_idx;
    pos_next              = pos;
    pos_set_next          = pos_set;
    dup_next              = dup;
    done_next             = 1'b0;
    status_next           = status;
    removed_id_next       = removed_id;
    removed_priority_next = removed_priority;
    ram_we                = 1'b0;
    ram_waddr             = pend_idx[AW-1:0];
    ram_wdata             = ram_rdata;
    ram_raddr             = ptr[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r_next            = cmd_t'(cmd);
          id_r_next             = task_id;
          prio_r_next           = task_priority;
          ptr_next              = '0;
          pos_next              = count;
          pos_set_next          = 1'b0;
          dup_next              = 1'b0;
          status_next           = ST_OK;
          removed_id_next       = '0;
          removed_priority_next = '0;
          case (cmd_t'(cmd))
            CMD_INSERT: state_next = S_SCAN;
            CMD_POP, CMD_DELETE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read a cycle, compare the word that returns
        if (ptr < count) begin
          ram_raddr     = ptr[AW-1:0];
          pend_v_next   = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = ptr + CW'(1);
        end
        if (pend_v) begin
          if (cmd_r == CMD_INSERT) begin
            if (ram_rdata.id == id_r) begin
              dup_next = 1'b1;
            end
            if (!pos_set && (ram_rdata.prio < prio_r)) begin
              pos_next     = pend_idx;
              pos_set_next = 1'b1;
            end
          end else if ((cmd_r == CMD_POP) || (ram_rdata.id == id_r)) begin
            removed_id_next       = ram_rdata.id;
            removed_priority_next = ram_rdata.prio;
            ptr_next              = pend_idx + CW'(1);
            pend_v_next           = 1'b0;
            state_next            = S_DROP;
          end
        end else if (ptr >= count) begin
          // walk finished with no word in flight
          if (cmd_r == CMD_INSERT) begin
            if (dup) begin
              status_next = ST_DUP;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else if (count == FULL_COUNT) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              ptr_next   = count;
              state_next = S_OPEN;
            end
          end else begin
            status_next = ST_NOTFOUND;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end

      S_DROP: begin
        // move each later entry one slot toward the head
        if (ptr < count) begin
          ram_raddr     = ptr[AW-1:0];
          pend_v_next   = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = ptr + CW'(1);
        end
        if (pend_v) begin
          ram_we    = 1'b1;
          ram_waddr = drop_addr[AW-1:0];
          ram_wdata = ram_rdata;
        end else if (ptr >= count) begin
          count_next = count - CW'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_OPEN: begin
        // move entries from the tail down to pos one slot back, then place
        if (ptr > pos) begin
          ram_raddr     = prev_ptr[AW-1:0];
          pend_v_next   = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = prev_ptr;
        end
        if (pend_v) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx[AW-1:0];
          ram_wdata = ram_rdata;
        end else if (ptr <= pos) begin
          ram_we         = 1'b1;
          ram_waddr      = pos[AW-1:0];
          ram_wdata.id   = id_r;
          ram_wdata.prio = prio_r;
          count_next     = count + CW'(1);
          done_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // the result word always comes back with the sequencer idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while sequencer busy");

  // the list never holds more than its capacity
  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("entry count beyond capacity");

  // the count moves only with a completed command
  assert property (@(posedge clk) disable iff (rst) !$stable(count) |-> done)
    else $error("entry count changed without a result word");

  // an accepted command either finishes at once or keeps the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted command lost");

  // failed commands remove nothing
  assert property (@(posedge clk) disable iff (rst)
      (done && (status != ST_OK)) |-> ((removed_id == '0) && (removed_priority == '0)))
    else $error("error result carries a removed entry");

endmodule

`default_nettype wire

// ===== dv/srtq_checker.sv =====
// Checker for the sorted priority task queue: predicts each result word and compares it.
module srtq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [srtq_pkg::CMD_W-1:0]    cmd,
  input  logic [srtq_pkg::ID_W-1:0]     task_id,
  input  logic [srtq_pkg::PRIO_W-1:0]   task_priority,
  input  logic                          done,
  input  logic [srtq_pkg::STATUS_W-1:0] status,
  input  logic [srtq_pkg::ID_W-1:0]     removed_id,
  input  logic [srtq_pkg::PRIO_W-1:0]   removed_priority,
  input  logic [srtq_pkg::OCC_W-1:0]    occupancy,
  output int                            errors,
  output int                            outstanding,
  output int                            checked,
  output int                            rejected_full,
  output int                            rejected_dup,
  output int                            peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import srtq_pkg::*;

  typedef struct packed {
    status_t           st;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
  } queue_reply_t;

  // Shadow copy of the sorted list
  logic [ID_W-1:0]   shadow_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
  int                shadow_len;

  queue_reply_t awaited_replies[$];
  int err_count;
  int n_checked;
  int n_full;
  int n_dup;
  int max_len;

  initial begin
    errors        = 0;
    outstanding   = 0;
    checked       = 0;
    rejected_full = 0;
    rejected_dup  = 0;
    peak_fill     = 0;
    err_count     = 0;
    n_checked     = 0;
    n_full        = 0;
    n_dup         = 0;
    max_len       = 0;
    shadow_len    = 0;
  end

  // Close the gap left by a removed entry
  function automatic void close_gap(int pos);
    for (int k = pos; k + 1 < shadow_len; k++) begin
      shadow_id[k]   = shadow_id[k + 1];
      shadow_prio[k] = shadow_prio[k + 1];
    end
    shadow_len--;
  endfunction

  // Apply one command word to the shadow list and return the result word it gives
  function automatic queue_reply_t apply_command(cmd_t c, logic [ID_W-1:0] id,
                                                 logic [PRIO_W-1:0] pr);
    queue_reply_t r;
    int hit;
    int pos;
    r.st   = ST_OK;
    r.id   = '0;
    r.prio = '0;
    hit    = -1;
    for (int k = 0; k < shadow_len; k++)
      if (hit < 0 && shadow_id[k] == id) hit = k;
    case (c)
      CMD_INSERT: begin
        // duplicate id wins over full
        if (hit >= 0) r.st = ST_DUP;
        else if (shadow_len >= QUEUE_DEPTH) r.st = ST_FULL;
        else begin
          pos = shadow_len;
          for (int k = 0; k < shadow_len; k++)
            if (pos == shadow_len && shadow_prio[k] < pr) pos = k;
          for (int k = shadow_len; k > pos; k--) begin
            shadow_id[k]   = shadow_id[k - 1];
            shadow_prio[k] = shadow_prio[k - 1];
          end
          shadow_id[pos]   = id;
          shadow_prio[pos] = pr;
          shadow_len++;
        end
      end
      CMD_POP: begin
        if (shadow_len == 0) r.st = ST_EMPTY;
        else begin
          r.id   = shadow_id[0];
          r.prio = shadow_prio[0];
          close_gap(0);
        end
      end
      CMD_DELETE: begin
        if (shadow_len == 0) r.st = ST_EMPTY;
        else if (hit < 0) r.st = ST_NOTFOUND;
        else begin
          r.id   = shadow_id[hit];
          r.prio = shadow_prio[hit];
          close_gap(hit);
        end
      end
      default: ;  // unused command leaves the list alone
    endcase
    r.occ = OCC_W'(shadow_len);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [ID_W-1:0] exp_v,
                                        logic [ID_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst) begin
      shadow_len = 0;
      awaited_replies.delete();
    end else begin
      // Result word leaving the block this cycle
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result word with nothing outstanding: status %0d id %0h",
                   $time, status, removed_id);
          err_count++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("status", ID_W'(want.st), ID_W'(status));
          compare_field("removed_id", want.id, removed_id);
          compare_field("removed_priority", ID_W'(want.prio), ID_W'(removed_priority));
          compare_field("occupancy", ID_W'(want.occ), ID_W'(occupancy));
          n_checked++;
          if (want.st == ST_FULL) n_full++;
          if (want.st == ST_DUP) n_dup++;
        end
      end
      // Command word taken this cycle
      if (start && !busy) begin
        awaited_replies.push_back(apply_command(cmd_t'(cmd), task_id, task_priority));
        if (shadow_len > max_len) max_len = shadow_len;
      end
    end
    errors        <= err_count;
    outstanding   <= awaited_replies.size();
    checked       <= n_checked;
    rejected_full <= n_full;
    rejected_dup  <= n_dup;
    peak_fill     <= max_len;
  end

endmodule

// ===== dv/tb_sorted_priority_task_queue.sv =====
// Testbench top for the sorted priority task queue: command stimulus and verdict.
module tb_sorted_priority_task_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import srtq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int N_RANDOM    = 1875;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 24;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic [CMD_W-1:0]    cmd           = CMD_NONE;
  logic [ID_W-1:0]     task_id       = '0;
  logic [PRIO_W-1:0]   task_priority = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     removed_id;
  logic [PRIO_W-1:0]   removed_priority;
  logic [OCC_W-1:0]    occupancy;

  int errors;
  int outstanding;
  int checked;
  int rejected_full;
  int rejected_dup;
  int peak_fill;

  int cycle_count = 0;
  int sender_idle_pct = 29;
  int words_sent = 0;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  always #6 clk = ~clk;

  sorted_priority_task_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .task_id(task_id), .task_priority(task_priority),
    .done(done), .status(status), .removed_id(removed_id),
    .removed_priority(removed_priority), .occupancy(occupancy)
  );

  srtq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .task_id(task_id), .task_priority(task_priority),
    .done(done), .status(status), .removed_id(removed_id),
    .removed_priority(removed_priority), .occupancy(occupancy),
    .errors(errors), .outstanding(outstanding), .checked(checked),
    .rejected_full(rejected_full), .rejected_dup(rejected_dup), .peak_fill(peak_fill)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one command word, hold it until taken, then maybe idle a while
  task automatic issue(cmd_t c, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
    int gap;
    start         <= 1'b1;
    cmd           <= c;
    task_id       <= id;
    task_priority <= pr;
    do @(posedge clk); while (busy);
    words_sent++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly ids from a small pool so duplicates and deletes hit stored entries
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 80) return id_pool[$urandom_range(POOL_SIZE - 1)];
    return ID_W'($urandom);
  endfunction

  // Mix of full-range, tied and extreme priorities
  function automatic logic [PRIO_W-1:0] pick_prio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return PRIO_W'($urandom_range(255));
    if (roll < 80) return PRIO_W'($urandom_range(3) * 85);
    return $urandom_range(1) ? 8'hFF : 8'h00;
  endfunction

  initial begin
    int bias;
    int ins_pct;
    int roll;
    int n;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty errors, extremes, ties, duplicate, absent id, fill to full
    issue(CMD_POP, 16'h0000, 8'h00);
    issue(CMD_DELETE, 16'h0005, 8'h00);
    issue(CMD_INSERT, 16'h0000, 8'h00);
    issue(CMD_INSERT, 16'hFFFF, 8'hFF);
    issue(CMD_INSERT, 16'h0000, 8'h80);
    issue(CMD_INSERT, 16'h0001, 8'hFF);
    issue(CMD_INSERT, 16'h0002, 8'h00);
    issue(CMD_POP, 16'h0000, 8'h00);
    issue(CMD_DELETE, 16'h1234, 8'h00);
    issue(CMD_DELETE, 16'h0002, 8'h00);
    issue(CMD_NONE, 16'hFFFF, 8'hFF);
    for (int k = 0; k < QUEUE_DEPTH - 2; k++)
      issue(CMD_INSERT, ID_W'(16'hA000 + k), PRIO_W'(k * 17));
    issue(CMD_INSERT, 16'h0000, 8'h40);
    issue(CMD_INSERT, 16'h7777, 8'h40);

    // Random: blocks that lean toward filling, draining or neither
    n = 0;
    bias = 0;
    while (n < N_RANDOM) begin
      if (n < N_RANDOM / 3) sender_idle_pct = 29;
      else if (n < 2 * N_RANDOM / 3) sender_idle_pct = 46;
      else sender_idle_pct = 0;
      if (n % 32 == 0) bias = $urandom_range(2);
      ins_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      roll = $urandom_range(99);
      if ($urandom_range(49) == 0) begin
        issue(CMD_NONE, ID_W'($urandom), PRIO_W'($urandom));
      end else begin
        if (roll < ins_pct) issue(CMD_INSERT, pick_id(), pick_prio());
        else if (roll < ins_pct + (100 - ins_pct) / 2)
          issue(CMD_POP, ID_W'($urandom), PRIO_W'($urandom));
        else issue(CMD_DELETE, pick_id(), PRIO_W'($urandom));
        n++;
      end
    end
    start <= 1'b0;

    // Drain the remaining result words, then watch for strays
    while (outstanding != 0) @(posedge clk);
    repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d command words, %0d result words checked", words_sent, checked);
    $display("Full rejections %0d, duplicate rejections %0d, peak fill %0d of %0d",
             rejected_full, rejected_dup, peak_fill, QUEUE_DEPTH);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/srtq_pkg.sv
design/srtq_ram.sv
design/sorted_priority_task_queue.sv
dv/srtq_checker.sv
dv/tb_sorted_priority_task_queue.sv
